// ===== sv/dws_pkg.sv =====
// Package for the deque with search: request codes, result status codes,
// controller states and the command/status structs between ctrl and datapath.
// No dependencies.
package dws_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_READOUT    = 3'd4,
    FN_SEARCH     = 3'd5
  } dws_func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } dws_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POP_WAIT,
    ST_WALK,
    ST_SEARCH
  } dws_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic        req_take;    // latch the request fields
    logic        push_front;
    logic        push_back;
    logic        pop_front;   // read front entry, advance front
    logic        pop_back;    // read back entry, shrink count
    logic        rd_first;    // read element 0 of a walk
    logic        rd_next;     // read the following element of a walk
    logic        out_load;    // load the output register
    dws_status_e out_status;
    logic        out_data;    // take data_out from the read register
    logic        out_pos;     // take position from the walk index
    logic        out_last;
  } dws_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    dws_func_e func;
    logic      empty;
    logic      full;
    logic      match;     // read word equals the search word
    logic      at_last;   // walk index points at the back element
    logic      out_free;  // output register can take a result this cycle
  } dws_stat_t;

endpackage

// ===== sv/dws_if.sv =====
// Handshake interfaces for the deque with search: request and result channels.
// Depends on dws_pkg for field widths.
interface dws_req_if
  import dws_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic        [FUNC_W-1:0]   func;
  logic signed [DATA_W-1:0]   value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface dws_rsp_if
  import dws_pkg::*;
#(
  parameter int unsigned POS_W = 5
) ();
  logic                       valid;
  logic                       ready;
  logic        [STATUS_W-1:0] status;
  logic signed [DATA_W-1:0]   data_out;
  logic        [POS_W-1:0]    position;
  logic                       last;

  modport source (output valid, output status, output data_out, output position,
                  output last, input ready);
  modport sink   (input valid, input status, input data_out, input position,
                  input last, output ready);
endinterface

// ===== sv/dws_ctrl.sv =====
// Controller state machine for the deque with search.
// Depends on dws_pkg; drives dws_cmd_t, reads dws_stat_t from dws_dpath.
module dws_ctrl
  import dws_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  dws_stat_t stat_i,
  output dws_cmd_t  cmd_o
);

  dws_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (stat_i.func)
          FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (stat_i.out_free) state_d = ST_IDLE;
          end
          FN_POP_FRONT, FN_POP_BACK: begin
            if (!stat_i.empty) state_d = ST_POP_WAIT;
            else if (stat_i.out_free) state_d = ST_IDLE;
          end
          FN_READOUT: begin
            if (!stat_i.empty) state_d = ST_WALK;
            else if (stat_i.out_free) state_d = ST_IDLE;
          end
          FN_SEARCH: begin
            if (!stat_i.empty) state_d = ST_SEARCH;
            else if (stat_i.out_free) state_d = ST_IDLE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_POP_WAIT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      ST_WALK: begin
        if (stat_i.out_free && stat_i.at_last) state_d = ST_IDLE;
      end
      ST_SEARCH: begin
        if ((stat_i.match || stat_i.at_last) && stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = STAT_OK;
    req_ready_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.req_take = req_valid_i;
      end
      ST_DISPATCH: begin
        case (stat_i.func)
          FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (stat_i.out_free) begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_last   = 1'b1;
              cmd_o.out_status = stat_i.full ? STAT_FULL : STAT_OK;
              cmd_o.push_front = !stat_i.full && (stat_i.func == FN_PUSH_FRONT);
              cmd_o.push_back  = !stat_i.full && (stat_i.func == FN_PUSH_BACK);
            end
          end
          FN_POP_FRONT, FN_POP_BACK, FN_READOUT, FN_SEARCH: begin
            if (stat_i.empty) begin
              if (stat_i.out_free) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = STAT_EMPTY;
              end
            end else begin
              cmd_o.pop_front = (stat_i.func == FN_POP_FRONT);
              cmd_o.pop_back  = (stat_i.func == FN_POP_BACK);
              cmd_o.rd_first  = (stat_i.func == FN_READOUT) || (stat_i.func == FN_SEARCH);
            end
          end
          default: ;
        endcase
      end
      ST_POP_WAIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_data = 1'b1;
          cmd_o.out_last = 1'b1;
        end
      end
      ST_WALK: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_data = 1'b1;
          cmd_o.out_last = stat_i.at_last;
          cmd_o.rd_next  = !stat_i.at_last;
        end
      end
      ST_SEARCH: begin
        if (stat_i.match) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_pos  = 1'b1;
            cmd_o.out_last = 1'b1;
          end
        end else if (stat_i.at_last) begin
          if (stat_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_last   = 1'b1;
            cmd_o.out_status = STAT_NOTFOUND;
          end
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/dws_dpath.sv =====
// Datapath for the deque with search: ring memory, front/count pointers,
// walk index, search compare and the result output register.
// Depends on dws_pkg; driven by dws_ctrl through dws_cmd_t.
module dws_dpath
  import dws_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned POS_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dws_cmd_t                 cmd_i,
  output dws_stat_t                stat_o,
  input  logic        [FUNC_W-1:0] req_func_i,
  input  logic signed [DATA_W-1:0] req_value_i,
  input  logic                     rsp_ready_i,
  output logic                     rsp_valid_o,
  output dws_status_e              rsp_status_o,
  output logic signed [DATA_W-1:0] rsp_data_o,
  output logic        [POS_W-1:0]  rsp_position_o,
  output logic                     rsp_last_o
);

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = POS_W;

  logic signed [DATA_W-1:0] mem [DEPTH];

  dws_func_e                func_q;
  logic signed [DATA_W-1:0] value_q;
  logic        [ADDR_W-1:0] front_q, front_d;
  logic        [CNT_W-1:0]  count_q, count_d;
  logic        [ADDR_W-1:0] idx_q, idx_d;
  logic signed [DATA_W-1:0] rdata_q;

  logic                     rsp_valid_q;
  dws_status_e              rsp_status_q;
  logic signed [DATA_W-1:0] rsp_data_q;
  logic        [POS_W-1:0]  rsp_pos_q;
  logic                     rsp_last_q;

  logic                     wr_en, rd_en;
  logic        [ADDR_W-1:0] wr_addr, rd_addr;
  logic        [ADDR_W-1:0] idx_inc;
  logic        [ADDR_W-1:0] back_addr, tail_addr, next_addr;
  logic        [ADDR_W-1:0] front_dec, front_inc;

  // Ring slot: (base + off) mod DEPTH, with base, off < DEPTH
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (ADDR_W + 1)'(DEPTH)) begin
      sum = sum - (ADDR_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  assign idx_inc   = idx_q + ADDR_W'(1);
  assign tail_addr = slot_of(front_q, count_q[ADDR_W-1:0]);
  assign back_addr = slot_of(front_q, ADDR_W'(count_q - CNT_W'(1)));
  assign next_addr = slot_of(front_q, idx_inc);
  assign front_dec = (front_q == '0) ? ADDR_W'(DEPTH - 1) : front_q - ADDR_W'(1);
  assign front_inc = (front_q == ADDR_W'(DEPTH - 1)) ? '0 : front_q + ADDR_W'(1);

  always_comb begin
    wr_en   = cmd_i.push_front || cmd_i.push_back;
    wr_addr = cmd_i.push_front ? front_dec : tail_addr;
    rd_en   = cmd_i.pop_front || cmd_i.pop_back || cmd_i.rd_first || cmd_i.rd_next;
    rd_addr = front_q;
    if (cmd_i.pop_back) rd_addr = back_addr;
    else if (cmd_i.rd_next) rd_addr = next_addr;

    front_d = front_q;
    count_d = count_q;
    if (cmd_i.push_front) begin
      front_d = front_dec;
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.push_back) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop_front) begin
      front_d = front_inc;
      count_d = count_q - CNT_W'(1);
    end else if (cmd_i.pop_back) begin
      count_d = count_q - CNT_W'(1);
    end

    idx_d = idx_q;
    if (cmd_i.rd_first) idx_d = '0;
    else if (cmd_i.rd_next) idx_d = idx_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      if (cmd_i.out_load) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.req_take) begin
      func_q  <= dws_func_e'(req_func_i);
      value_q <= req_value_i;
    end
    if (cmd_i.out_load) begin
      rsp_status_q <= cmd_i.out_status;
      rsp_data_q   <= cmd_i.out_data ? rdata_q : '0;
      rsp_pos_q    <= cmd_i.out_pos ? POS_W'(idx_q) + POS_W'(1) : '0;
      rsp_last_q   <= cmd_i.out_last;
    end
  end

  // Element memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= value_q;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  assign stat_o.func     = func_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == CNT_W'(DEPTH));
  assign stat_o.match    = (rdata_q == value_q);
  assign stat_o.at_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign stat_o.out_free = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o    = rsp_valid_q;
  assign rsp_status_o   = rsp_status_q;
  assign rsp_data_o     = rsp_data_q;
  assign rsp_position_o = rsp_pos_q;
  assign rsp_last_o     = rsp_last_q;

endmodule

// ===== sv/deque_with_search.sv =====
// Deque with search: a bounded double-ended queue of signed 32-bit words in
// a ring memory of DEPTH entries, with a controller FSM and a datapath.
// Depends on dws_pkg, dws_if, dws_ctrl and dws_dpath.
//
// Each request transaction pushes at the front or back, pops from the front
// or back, reads out every element front to back, or searches for a word and
// answers with the 1-based position of the first match. Requests are handled
// one at a time; the request channel is ready only while the controller is
// idle. A push, or any request on an empty queue, is answered from the
// dispatch state; a pop passes through a wait state for the registered
// memory read. A readout and a search step through the elements front to back;
// both are bound by the single read port of the element memory, which delivers
// one element per cycle. Results go out through a one-entry output register, so
// the next request is accepted while the last result still waits; back
// pressure on the result channel stalls the walk without losing data. Codes
// six and seven are accepted and dropped without a result. No clearing pass
// runs after reset: the queue starts empty and only written entries are read.
module deque_with_search
  import dws_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dws_req_if.sink    req_i,
  dws_rsp_if.source  rsp_o
);

  localparam int unsigned POS_W = $clog2(DEPTH + 1);

  dws_cmd_t    cmd;
  dws_stat_t   stat;
  dws_status_e rsp_status;

  // Controller: sequences each request over the datapath
  dws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: ring memory, pointers, compare and output register
  dws_dpath #(
    .DEPTH (DEPTH),
    .POS_W (POS_W)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_func_i     (req_i.func),
    .req_value_i    (req_i.value),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_status_o   (rsp_status),
    .rsp_data_o     (rsp_o.data_out),
    .rsp_position_o (rsp_o.position),
    .rsp_last_o     (rsp_o.last)
  );

  assign rsp_o.status = rsp_status;

endmodule
